[rtl/utxf_pkg.sv]
// ---------------------------------------------------------------------------
// utxf_pkg - shared types and constants for the uart transmit ring fifo
// Request and result records, request codes, overflow marker bytes.
// ---------------------------------------------------------------------------
package utxf_pkg;

  // default storage and chunk limits
  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned MAX_CHUNK_DEF = 32;

  // ring size register
  localparam logic [3:0] SIZE_LOG2_RESET = 4'd8;
  localparam logic [3:0] SIZE_LOG2_MIN   = 4'd6;
  localparam logic [3:0] SIZE_LOG2_MAX   = 4'd8;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READY = 2'd1;
  localparam logic [1:0] REQ_EOM   = 2'd2;

  // overflow marker "!OVF!"
  localparam int unsigned MARK_LEN = 5;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_F      = 8'h46;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       chunk_start;
    logic [5:0] chunk_len;
    logic       tx_empty;
  } req_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       send_enabled;
    logic [7:0] queued_count;
    logic       overflow_hit;
  } res_t;

  // marker byte at position idx
  function automatic logic [7:0] marker_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd1:    b = CH_O;
      3'd2:    b = CH_V;
      3'd3:    b = CH_F;
      default: b = CH_BANG;
    endcase
    return b;
  endfunction

endpackage

[rtl/utxf_ram.sv]
// ---------------------------------------------------------------------------
// utxf_ram - generic single-clock ram
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module utxf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/uart_tx_ring_fifo_with_overflow_mark_top.sv]
// ---------------------------------------------------------------------------
// uart_tx_ring_fifo_with_overflow_mark_top - transmit byte fifo with overflow mark
// Ring of 2^size_log2 bytes in one ram. A chunk start without room flushes
// the queue and queues "!OVF!" ahead of the byte.
//
//   channel   signals                 handshake
//   --------  ----------------------  -----------------------------------
//   request   start, busy, req        taken at edge with start & !busy
//   result    done, result            valid for the single cycle done is high
//   config    cfg_we, cfg_wdata       written at edge with cfg_we
//
// A write, end-of-message, unused code or a ready that sends nothing is
// done in ST_IDLE and busy stays low. A ready that sends a byte waits in
// ST_READ on the registered ram read port, with busy high. A flushing write does six
// ram writes through the single write port, with busy high in ST_MARK. The
// result is registered and comes in the cycle after the last step. Reset clears pointers
// and sending flag and resets the size register; ram contents are not cleared. The receiver cannot
// stall. DEPTH must be a power of two.
// ---------------------------------------------------------------------------
module uart_tx_ring_fifo_with_overflow_mark_top #(
  parameter int unsigned DEPTH     = utxf_pkg::DEPTH_DEF,
  parameter int unsigned MAX_CHUNK = utxf_pkg::MAX_CHUNK_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  utxf_pkg::req_t  req,
  output logic            done,
  output utxf_pkg::res_t  result,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_wdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam logic [3:0]  DEPTH_LG = 4'(AW);
  localparam logic [2:0]  MARK_LAST = 3'(utxf_pkg::MARK_LEN);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_MARK = 3'b100
  } state_t;

  state_t         state, state_next;
  logic [PW-1:0]  wp, wp_next;
  logic [PW-1:0]  rp, rp_next;
  logic           sending_on, sending_on_next;
  logic [3:0]     size_log2;
  logic [2:0]     mark_idx, mark_idx_next;
  logic [7:0]     hold_byte, hold_byte_next;
  utxf_pkg::res_t result_next;
  logic           res_load;

  logic           accept;
  logic [3:0]     lg;
  logic [AW-1:0]  mask;
  logic [PW-1:0]  occ_now, occ_after, space;
  logic [5:0]     len_c;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;

  // ring mask from size register, clamped and limited to the ram depth
  always_comb begin
    lg = size_log2;
    if (lg < utxf_pkg::SIZE_LOG2_MIN) lg = utxf_pkg::SIZE_LOG2_MIN;
    if (lg > utxf_pkg::SIZE_LOG2_MAX) lg = utxf_pkg::SIZE_LOG2_MAX;
    if (32'(lg) > AW) lg = DEPTH_LG;
    mask = AW'((PW'(1) << lg) - PW'(1));
  end

  // occupancy, free space, clamped chunk length
  assign occ_now   = wp - rp;
  assign space     = (occ_now > PW'(mask)) ? '0 : PW'(mask) - occ_now;
  assign len_c     = (32'(req.chunk_len) > MAX_CHUNK) ? 6'(MAX_CHUNK) : req.chunk_len;
  assign ram_raddr = AW'(rp) & mask;

  // sequencer: read-modify-write of pointers and ram
  always_comb begin
    state_next      = state;
    wp_next         = wp;
    rp_next         = rp;
    sending_on_next = sending_on;
    mark_idx_next   = mark_idx;
    hold_byte_next  = hold_byte;
    ram_we          = 1'b0;
    ram_waddr       = AW'(wp) & mask;
    ram_wdata       = req.data_byte;
    res_load        = 1'b0;
    result_next              = result;
    result_next.out_valid    = 1'b0;
    result_next.out_byte     = 8'd0;
    result_next.overflow_hit = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (req.req_type == utxf_pkg::REQ_WRITE) begin
            if (req.chunk_start && (space < PW'(len_c))) begin
              // flush: restart at read pointer with the first marker byte
              ram_we         = 1'b1;
              ram_waddr      = AW'(rp) & mask;
              ram_wdata      = utxf_pkg::marker_byte(3'd0);
              wp_next        = rp + PW'(1);
              mark_idx_next  = 3'd1;
              hold_byte_next = req.data_byte;
              state_next     = ST_MARK;
            end else begin
              ram_we   = 1'b1;
              wp_next  = wp + PW'(1);
              res_load = 1'b1;
            end
          end else if (req.req_type == utxf_pkg::REQ_READY) begin
            if (occ_now != '0) begin
              if (req.tx_empty) begin
                state_next = ST_READ;
              end else begin
                res_load = 1'b1;
              end
            end else begin
              sending_on_next = 1'b0;
              res_load        = 1'b1;
            end
          end else if (req.req_type == utxf_pkg::REQ_EOM) begin
            sending_on_next = 1'b1;
            res_load        = 1'b1;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      ST_READ: begin
        // ram data for the read pointer is ready now
        result_next.out_valid = 1'b1;
        result_next.out_byte  = ram_rdata;
        rp_next               = rp + PW'(1);
        res_load              = 1'b1;
        state_next            = ST_IDLE;
      end
      ST_MARK: begin
        // rest of the marker, then the held byte
        ram_we    = 1'b1;
        ram_wdata = (mark_idx == MARK_LAST) ? hold_byte
                                            : utxf_pkg::marker_byte(mark_idx);
        wp_next   = wp + PW'(1);
        if (mark_idx == MARK_LAST) begin
          result_next.overflow_hit = 1'b1;
          res_load                 = 1'b1;
          state_next               = ST_IDLE;
        end else begin
          mark_idx_next = mark_idx + 3'd1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    occ_after                = wp_next - rp_next;
    result_next.send_enabled = sending_on_next;
    result_next.queued_count = (32'(occ_after) > 32'd255) ? 8'hFF : 8'(occ_after);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wp         <= '0;
      rp         <= '0;
      sending_on <= 1'b0;
      size_log2  <= utxf_pkg::SIZE_LOG2_RESET;
      done       <= 1'b0;
      mark_idx   <= 3'd0;
    end else begin
      state      <= state_next;
      wp         <= wp_next;
      rp         <= rp_next;
      sending_on <= sending_on_next;
      done       <= res_load;
      mark_idx   <= mark_idx_next;
      if (cfg_we) begin
        size_log2 <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_byte <= hold_byte_next;
    if (res_load) begin
      result <= result_next;
    end
  end

  // byte store
  utxf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  // a result never shows while a transaction is still in work
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // a byte read always comes out in the next cycle
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (done && result.out_valid))
    else $error("read did not produce a sent byte");

  // after a flush exactly marker plus byte are queued
  a_ovf_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow_hit) |-> (result.queued_count == 8'd6))
    else $error("overflow result with wrong occupancy");
`endif

endmodule

[sim/testbench.sv]
// ---------------------------------------------------------------------------
// testbench - uart transmit ring fifo with overflow mark
// Drives write, ready, end-of-message and unused requests through the
// start/busy port. A short stimulus table runs first, then random message
// traffic over several ring sizes. Every result is checked against a table
// value or a software model of the fifo kept in this file.
// ---------------------------------------------------------------------------
module testbench;
  import utxf_pkg::*;

  // unused request code, must change nothing
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned N_PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 130;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  req_t       req;
  logic       done;
  res_t       result;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  // one row of the directed stimulus; the ring size column is written when it changes
  typedef struct {
    logic [3:0]  size_log2;
    req_t        item;
    int unsigned reps;
    bit          typed;
    res_t        want;
  } stim_row_t;

  // fifo model state
  logic [7:0] ring_bytes [DEPTH_DEF];
  logic [8:0] wr_ptr;
  logic [8:0] rd_ptr;
  logic       tx_on;
  logic [3:0] size_reg;

  res_t fifo_outcomes_due [$];
  int unsigned err_count;
  int unsigned n_items;
  int unsigned n_flush;
  int unsigned n_sent;
  int unsigned n_sizes;
  int unsigned idle_cycles;
  bit          gaps_on;

  uart_tx_ring_fifo_with_overflow_mark_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model: queue one byte at the write pointer
  function automatic void ring_push(logic [7:0] b, logic [7:0] mask);
    ring_bytes[wr_ptr[7:0] & mask] = b;
    wr_ptr = wr_ptr + 9'd1;
  endfunction

  // model: outcome of one transaction, updates the fifo state
  function automatic res_t fifo_next_outcome(req_t r);
    res_t        o;
    int unsigned lg;
    logic [7:0]  mask;
    logic [8:0]  occ;
    int unsigned room;
    int unsigned len;
    o = '0;
    lg = size_reg;
    if (lg < SIZE_LOG2_MIN) lg = SIZE_LOG2_MIN;
    if (lg > SIZE_LOG2_MAX) lg = SIZE_LOG2_MAX;
    mask = 8'((1 << lg) - 1);
    occ = wr_ptr - rd_ptr;
    case (r.req_type)
      REQ_WRITE: begin
        if (r.chunk_start) begin
          room = (occ > mask) ? 0 : mask - occ;
          len = (r.chunk_len > MAX_CHUNK_DEF) ? MAX_CHUNK_DEF : r.chunk_len;
          // no room for the chunk: drop the queue and mark the loss
          if (room < len) begin
            wr_ptr = rd_ptr;
            ring_push(CH_BANG, mask);
            ring_push(CH_O, mask);
            ring_push(CH_V, mask);
            ring_push(CH_F, mask);
            ring_push(CH_BANG, mask);
            o.overflow_hit = 1'b1;
          end
        end
        ring_push(r.data_byte, mask);
      end
      REQ_READY: begin
        if (occ != 0) begin
          if (r.tx_empty) begin
            o.out_valid = 1'b1;
            o.out_byte = ring_bytes[rd_ptr[7:0] & mask];
            rd_ptr = rd_ptr + 9'd1;
          end
        end else begin
          tx_on = 1'b0;
        end
      end
      REQ_EOM: begin
        tx_on = 1'b1;
      end
      default: ;
    endcase
    occ = wr_ptr - rd_ptr;
    o.send_enabled = tx_on;
    o.queued_count = (occ > 9'd255) ? 8'd255 : occ[7:0];
    return o;
  endfunction

  function automatic stim_row_t mk_item(logic [3:0] sz, logic [1:0] rt, logic [7:0] d,
                                        logic cs, logic [5:0] len, logic txe,
                                        int unsigned reps);
    stim_row_t row;
    row.size_log2 = sz;
    row.item.req_type = rt;
    row.item.data_byte = d;
    row.item.chunk_start = cs;
    row.item.chunk_len = len;
    row.item.tx_empty = txe;
    row.reps = reps;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t mk_typed(logic [3:0] sz, logic [1:0] rt, logic [7:0] d,
                                         logic cs, logic [5:0] len, logic txe,
                                         logic v, logic [7:0] b, logic en,
                                         logic [7:0] cnt, logic ovf);
    stim_row_t row;
    row = mk_item(sz, rt, d, cs, len, txe, 1);
    row.typed = 1'b1;
    row.want.out_valid = v;
    row.want.out_byte = b;
    row.want.send_enabled = en;
    row.want.queued_count = cnt;
    row.want.overflow_hit = ovf;
    return row;
  endfunction

  // present one transaction and wait for it to be taken
  task automatic send_item(req_t r, bit typed, res_t want);
    res_t got;
    if (gaps_on && $urandom_range(99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 30) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = fifo_next_outcome(r);
    fifo_outcomes_due.push_back(typed ? want : got);
    n_items++;
    if (got.overflow_hit) n_flush++;
    if (got.out_valid) n_sent++;
  endtask

  // ring size write, only with nothing in flight
  task automatic write_ring_size(logic [3:0] v);
    start <= 1'b0;
    while (fifo_outcomes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = v;
    n_sizes++;
  endtask

  // empty the fifo so a size change never exposes stale slots
  task automatic drain_fifo();
    req_t r;
    r = '0;
    r.req_type = REQ_READY;
    r.tx_empty = 1'b1;
    while (wr_ptr != rd_ptr) send_item(r, 1'b0, '0);
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && done) begin
      if (fifo_outcomes_due.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: valid=%0b byte=%02h en=%0b count=%0d ovf=%0b",
                   result.out_valid, result.out_byte, result.send_enabled,
                   result.queued_count, result.overflow_hit);
      end else begin
        want = fifo_outcomes_due.pop_front();
        if (result.out_valid !== want.out_valid || result.out_byte !== want.out_byte ||
            result.send_enabled !== want.send_enabled ||
            result.queued_count !== want.queued_count ||
            result.overflow_hit !== want.overflow_hit) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected valid=%0b byte=%02h en=%0b count=%0d ovf=%0b, got valid=%0b byte=%02h en=%0b count=%0d ovf=%0b",
                     want.out_valid, want.out_byte, want.send_enabled,
                     want.queued_count, want.overflow_hit,
                     result.out_valid, result.out_byte, result.send_enabled,
                     result.queued_count, result.overflow_hit);
        end
      end
    end
  end

  // watchdog on cycles with no transaction either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("uart_tx_ring_fifo_with_overflow_mark_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   stim_rows [$];
    req_t        item;
    int unsigned chunk_left;
    int unsigned ready_pct;
    int unsigned pick;
    int unsigned ready_mix [N_PHASES];
    logic [3:0]  phase_sizes [N_PHASES];
    ready_mix = '{40, 15, 60, 25, 10, 45, 30};
    phase_sizes = '{4'd6, 4'd15, 4'd7, 4'd0, 4'd8, 4'd9, 4'd6};
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    wr_ptr = '0;
    rd_ptr = '0;
    tx_on = 1'b0;
    size_reg = SIZE_LOG2_RESET;
    err_count = 0;
    n_items = 0;
    n_flush = 0;
    n_sent = 0;
    n_sizes = 0;
    gaps_on = 1'b1;
    chunk_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty fifo, unused request, ready with and without tx empty
    stim_rows.push_back(mk_typed(4'd8, REQ_READY, 8'h00, 0, 6'd0, 1, 0, 8'h00, 0, 0, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_EOM, 8'h00, 0, 6'd0, 0, 0, 8'h00, 1, 0, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_READY, 8'h00, 0, 6'd0, 1, 0, 8'h00, 0, 0, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_UNUSED, 8'hFF, 1, 6'd63, 1, 0, 8'h00, 0, 0, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_WRITE, 8'hFF, 1, 6'd32, 0, 0, 8'h00, 0, 1, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_WRITE, 8'h00, 0, 6'd63, 1, 0, 8'h00, 0, 2, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_EOM, 8'hFF, 1, 6'd63, 0, 0, 8'h00, 1, 2, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_READY, 8'h00, 0, 6'd0, 0, 0, 8'h00, 1, 2, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_READY, 8'h00, 0, 6'd0, 1, 1, 8'hFF, 1, 1, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_READY, 8'h00, 0, 6'd0, 1, 1, 8'h00, 1, 0, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_READY, 8'h00, 0, 6'd0, 1, 0, 8'h00, 0, 0, 0));
    // zero chunk length never flushes; ready still sends with sending off
    stim_rows.push_back(mk_typed(4'd8, REQ_WRITE, 8'hA5, 1, 6'd0, 0, 0, 8'h00, 0, 1, 0));
    stim_rows.push_back(mk_typed(4'd8, REQ_READY, 8'h00, 0, 6'd0, 1, 1, 8'hA5, 0, 0, 0));
    // smallest ring: fill, then an oversized chunk start flushes and marks
    stim_rows.push_back(mk_item(4'd6, REQ_WRITE, 8'h00, 0, 6'd17, 1, 34));
    stim_rows.push_back(mk_typed(4'd6, REQ_WRITE, 8'h5A, 1, 6'd63, 0, 0, 8'h00, 0, 6, 1));
    stim_rows.push_back(mk_typed(4'd6, REQ_EOM, 8'h00, 0, 6'd0, 0, 0, 8'h00, 1, 6, 0));
    stim_rows.push_back(mk_typed(4'd6, REQ_READY, 8'h00, 0, 6'd0, 1, 1, CH_BANG, 1, 5, 0));
    stim_rows.push_back(mk_typed(4'd6, REQ_READY, 8'h00, 0, 6'd0, 1, 1, CH_O, 1, 4, 0));
    stim_rows.push_back(mk_typed(4'd6, REQ_READY, 8'h00, 0, 6'd0, 1, 1, CH_V, 1, 3, 0));
    stim_rows.push_back(mk_typed(4'd6, REQ_READY, 8'h00, 0, 6'd0, 1, 1, CH_F, 1, 2, 0));
    stim_rows.push_back(mk_typed(4'd6, REQ_READY, 8'h00, 0, 6'd0, 1, 1, CH_BANG, 1, 1, 0));
    stim_rows.push_back(mk_typed(4'd6, REQ_READY, 8'h00, 0, 6'd0, 1, 1, 8'h5A, 1, 0, 0));
    stim_rows.push_back(mk_typed(4'd6, REQ_READY, 8'h00, 0, 6'd0, 1, 0, 8'h00, 0, 0, 0));

    foreach (stim_rows[i]) begin
      if (stim_rows[i].size_log2 != size_reg) write_ring_size(stim_rows[i].size_log2);
      for (int k = 0; k < stim_rows[i].reps; k++) begin
        item = stim_rows[i].item;
        if (stim_rows[i].reps > 1) item.data_byte = 8'($urandom_range(255));
        send_item(item, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // random message traffic, one ring size and ready mix per phase
    for (int p = 0; p < N_PHASES; p++) begin
      drain_fifo();
      write_ring_size(phase_sizes[p]);
      ready_pct = ready_mix[p];
      gaps_on = (p != 2 && p != 3);
      chunk_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        item = '0;
        item.data_byte = 8'($urandom_range(255));
        item.chunk_len = 6'($urandom_range(63));
        item.tx_empty = ($urandom_range(99) < 85);
        if (chunk_left != 0 && $urandom_range(99) < 75) begin
          // rest of the current chunk
          item.req_type = REQ_WRITE;
          chunk_left--;
        end else begin
          pick = $urandom_range(99);
          if (pick < ready_pct) begin
            item.req_type = REQ_READY;
            item.chunk_start = 1'($urandom_range(1));
          end else if (pick < ready_pct + 8) begin
            item.req_type = REQ_EOM;
          end else if (pick < ready_pct + 11) begin
            item.req_type = REQ_UNUSED;
            item.chunk_start = 1'($urandom_range(1));
          end else if (pick < ready_pct + 16) begin
            item.req_type = REQ_WRITE;
          end else begin
            // new chunk, mostly legal lengths, some zero or oversized
            item.req_type = REQ_WRITE;
            item.chunk_start = 1'b1;
            pick = $urandom_range(99);
            if (pick < 10) item.chunk_len = 6'd0;
            else if (pick < 25) item.chunk_len = 6'($urandom_range(63, 33));
            else item.chunk_len = 6'($urandom_range(32, 1));
            chunk_left = (item.chunk_len == 0) ? 0 : item.chunk_len - 1;
          end
        end
        send_item(item, 1'b0, '0);
      end
    end

    // wait for the last results, then a short tail
    start <= 1'b0;
    while (fifo_outcomes_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fifo_outcomes_due.size() != 0) err_count++;

    $display("covered %0d transactions over %0d ring size writes", n_items, n_sizes);
    $display("%0d overflow flushes, %0d bytes handed to the transmitter, %0d errors",
             n_flush, n_sent, err_count);
    if (err_count == 0) begin
      $display("uart_tx_ring_fifo_with_overflow_mark_top verification clean");
    end else begin
      $display("uart_tx_ring_fifo_with_overflow_mark_top verification failed");
    end
    $finish;
  end

endmodule
